[src/assert_macros.svh]
// Assertion macros shared by the RTL of the canonical line editor.
// Include with the bare file name; the macros expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent assertion on an explicit clock and active-low reset.
`define CLE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CLE_ASSERT(lbl, prop, msg) \
  `CLE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define CLE_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CLE_ASSERT(lbl, prop, msg)

`endif

`endif

[src/cle_pkg.sv]
// Types and constants of the canonical line editor.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package cle_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAP_CR    = 3'd0;
  localparam logic [2:0] REG_CANONICAL = 3'd1;
  localparam logic [2:0] REG_ECHO      = 3'd2;
  localparam logic [2:0] REG_EXPAND_NL = 3'd3;
  localparam logic [2:0] REG_ERASE     = 3'd4;
  localparam logic [2:0] REG_EOF       = 3'd5;

  // Character constants.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  // Reset values of the byte registers.
  localparam logic [7:0] ERASE_RESET = 8'd127;
  localparam logic [7:0] EOF_RESET   = 8'd4;

  // Saturation limit of the line count.
  localparam logic [15:0] LINES_MAX = 16'hFFFF;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_ECHO   = 3'd1,
    KIND_READ   = 3'd2,
    KIND_EOF    = 3'd3,
    KIND_NODATA = 3'd4
  } kind_e;

  // One entry of the result buffer.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } res_t;

endpackage

`default_nettype wire

[src/cle_if.sv]
// Valid/ready channel interfaces of the canonical line editor.
// Depends on nothing; the result channel width of free_space is a parameter.
`default_nettype none

// Request channel: received bytes, read requests and flushes.
interface cle_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       rx_error;
  logic       batch_end;

  modport source (output valid, func, data_byte, rx_error, batch_end, input ready);
  modport sink   (input valid, func, data_byte, rx_error, batch_end, output ready);
endinterface

// Result channel: echo bytes, read bytes and status.
interface cle_res_if #(
  parameter int FreeW = 13
);
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       out_byte;
  logic             last;
  logic             wake;
  logic             line_end;
  logic [FreeW-1:0] free_space;
  logic [15:0]      lines_ready;

  modport source (output valid, kind, out_byte, last, wake, line_end, free_space,
                  lines_ready, input ready);
  modport sink   (input valid, kind, out_byte, last, wake, line_end, free_space,
                  lines_ready, output ready);
endinterface

`default_nettype wire

[src/cle_ring_store.sv]
// Byte ring store of the canonical line editor: one write port, one registered read.
// Depends on nothing else; instantiated by canonical_line_editor_core.
`default_nettype none

module cle_ring_store #(
  parameter int Depth = 4096
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire [$clog2(Depth)-1:0]     waddr_i,
  input  wire [7:0]                   wdata_i,
  input  wire [$clog2(Depth)-1:0]     raddr_i,
  output logic [7:0]                  rdata_o
);

  logic [7:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a write to the same address in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/canonical_line_editor_core.sv]
// Top level of the canonical line editor: request register, line discipline, result buffer.
// Depends on cle_pkg, cle_if.sv, cle_ring_store and assert_macros.svh.
//
// A request is registered on transfer and handled once the result buffer is empty
// or hands over its final entry in that cycle. Handling an item produces one to
// three results (three for an erase sequence, two for an expanded newline), which
// leave the three-entry result buffer one per cycle while the result port is ready.
// A new request is taken while the buffer still drains. The ring store is a
// single-port-write memory whose read is registered and addressed by the next read
// pointer, so a read request always finds its byte on the registered read output
// when it is handled. The store needs no clearing pass: only bytes that were
// written are ever read.
`default_nettype none

module canonical_line_editor_core #(
  parameter int BUF_DEPTH = 4096
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  cle_req_if.sink                      req_i,
  cle_res_if.source                    res_o,
  input  wire                          cfg_we_i,
  input  wire [2:0]                    cfg_index_i,
  input  wire [7:0]                    cfg_wdata_i
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(BUF_DEPTH - 1);
  localparam logic [CW-1:0] FILL_MAX = CW'(BUF_DEPTH);

  // Configuration registers.
  logic       map_cr_q, canon_q, echo_q, expand_q;
  logic [7:0] erase_q, eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cr_q <= 1'b1;
      canon_q  <= 1'b1;
      echo_q   <= 1'b1;
      expand_q <= 1'b1;
      erase_q  <= cle_pkg::ERASE_RESET;
      eof_q    <= cle_pkg::EOF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cle_pkg::REG_MAP_CR:    map_cr_q <= cfg_wdata_i[0];
        cle_pkg::REG_CANONICAL: canon_q  <= cfg_wdata_i[0];
        cle_pkg::REG_ECHO:      echo_q   <= cfg_wdata_i[0];
        cle_pkg::REG_EXPAND_NL: expand_q <= cfg_wdata_i[0];
        cle_pkg::REG_ERASE:     erase_q  <= cfg_wdata_i;
        cle_pkg::REG_EOF:       eof_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request register.
  logic       in_valid_q;
  logic [1:0] func_q;
  logic [7:0] data_q;
  logic       err_q, batch_q;
  logic       exec;

  assign req_i.ready = !in_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (exec) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= req_i.func;
      data_q  <= req_i.data_byte;
      err_q   <= req_i.rx_error;
      batch_q <= req_i.batch_end;
    end
  end

  // Discipline state.
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] fill_q, fill_d, comp_q, comp_d;
  logic [15:0]   pend_q, pend_d;
  logic          wakep_q, wakep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      comp_q  <= '0;
      pend_q  <= '0;
      wakep_q <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      fill_q  <= fill_d;
      comp_q  <= comp_d;
      pend_q  <= pend_d;
      wakep_q <= wakep_d;
    end
  end

  // Ring store.
  logic       mem_we;
  logic [7:0] mem_wdata, rd_data;

  cle_ring_store #(
    .Depth (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (mem_wdata),
    .raddr_i (rp_d),
    .rdata_o (rd_data)
  );

  // Result buffer.
  cle_pkg::res_t ent_q [3];
  cle_pkg::res_t ent_d [3];
  logic [1:0]    rem_q, idx_q, n_d;
  logic [CW-1:0] free_q;
  logic [15:0]   lines_q;
  logic          wake_q, lend_q, wake_d, lend_d;
  logic          q_free;

  assign q_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && res_o.ready);
  assign exec   = in_valid_q && q_free;

  // Line discipline: one request handled per cycle while the result buffer is free.
  always_comb begin
    logic [7:0]    ch;
    logic          is_erase, is_eof, woke, bump_line;
    logic [CW-1:0] fill_inc;

    ch        = (map_cr_q && (data_q == cle_pkg::CH_CR)) ? cle_pkg::CH_NL : data_q;
    is_erase  = canon_q && ((ch == cle_pkg::CH_BS) || (ch == erase_q));
    is_eof    = canon_q && (ch == eof_q);
    fill_inc  = fill_q + CW'(1);
    woke      = 1'b0;
    bump_line = 1'b0;

    wp_d      = wp_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    comp_d    = comp_q;
    pend_d    = pend_q;
    wakep_d   = wakep_q;
    mem_we    = 1'b0;
    mem_wdata = ch;
    n_d       = 2'd0;
    wake_d    = 1'b0;
    lend_d    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ent_d[i] = '{kind: cle_pkg::KIND_STATUS, out_byte: 8'h00};
    end

    if (exec) begin
      unique case (func_q)
        cle_pkg::FUNC_RX: begin
          if (!err_q) begin
            priority if (is_erase) begin
              // Erase the newest unfinished byte and, with echo on, echo backspace, space, backspace.
              if (fill_q > comp_q) begin
                wp_d   = (wp_q == '0) ? PTR_LAST : wp_q - AW'(1);
                fill_d = fill_q - CW'(1);
                if (echo_q) begin
                  ent_d[0] = '{kind: cle_pkg::KIND_ECHO, out_byte: cle_pkg::CH_BS};
                  ent_d[1] = '{kind: cle_pkg::KIND_ECHO, out_byte: cle_pkg::CH_SP};
                  ent_d[2] = '{kind: cle_pkg::KIND_ECHO, out_byte: cle_pkg::CH_BS};
                  n_d      = 2'd3;
                end
              end
            end else if (is_eof) begin
              bump_line = 1'b1;
              woke      = 1'b1;
            end else if (fill_q != FILL_MAX) begin
              // Store the byte; in canonical mode a newline or a full store finishes the line.
              mem_we = 1'b1;
              wp_d   = (wp_q == PTR_LAST) ? '0 : wp_q + AW'(1);
              fill_d = fill_inc;
              if (canon_q) begin
                if ((ch == cle_pkg::CH_NL) || (fill_inc == FILL_MAX)) begin
                  comp_d    = fill_inc;
                  bump_line = 1'b1;
                  woke      = 1'b1;
                end
              end else begin
                woke = 1'b1;
              end
              if (echo_q) begin
                if ((ch == cle_pkg::CH_NL) && expand_q) begin
                  ent_d[0] = '{kind: cle_pkg::KIND_ECHO, out_byte: cle_pkg::CH_CR};
                  ent_d[1] = '{kind: cle_pkg::KIND_ECHO, out_byte: cle_pkg::CH_NL};
                  n_d      = 2'd2;
                end else begin
                  ent_d[0] = '{kind: cle_pkg::KIND_ECHO, out_byte: ch};
                  n_d      = 2'd1;
                end
              end
            end else begin
              // The store is full: the byte is dropped without an echo.
            end
          end
          if (bump_line && (pend_q != cle_pkg::LINES_MAX)) begin
            pend_d = pend_q + 16'd1;
          end
          if (woke) begin
            wakep_d = 1'b1;
          end
          if (n_d == 2'd0) begin
            n_d = 2'd1;
          end
          if (batch_q) begin
            wake_d  = wakep_q || woke;
            wakep_d = 1'b0;
          end
        end
        cle_pkg::FUNC_READ: begin
          n_d = 2'd1;
          if (fill_q == '0) begin
            if (canon_q && (pend_q != 16'd0)) begin
              pend_d   = pend_q - 16'd1;
              ent_d[0] = '{kind: cle_pkg::KIND_EOF, out_byte: 8'h00};
            end else begin
              ent_d[0] = '{kind: cle_pkg::KIND_NODATA, out_byte: 8'h00};
            end
          end else if (canon_q && (pend_q == 16'd0)) begin
            ent_d[0] = '{kind: cle_pkg::KIND_NODATA, out_byte: 8'h00};
          end else begin
            // Take the oldest stored byte.
            rp_d     = (rp_q == PTR_LAST) ? '0 : rp_q + AW'(1);
            fill_d   = fill_q - CW'(1);
            if (comp_q != '0) begin
              comp_d = comp_q - CW'(1);
            end
            ent_d[0] = '{kind: cle_pkg::KIND_READ, out_byte: rd_data};
            if (canon_q && (rd_data == cle_pkg::CH_NL)) begin
              lend_d = 1'b1;
              if (pend_q != 16'd0) begin
                pend_d = pend_q - 16'd1;
              end
            end
          end
        end
        cle_pkg::FUNC_FLUSH: begin
          wp_d   = '0;
          rp_d   = '0;
          fill_d = '0;
          comp_d = '0;
          pend_d = '0;
          n_d    = 2'd1;
        end
        default: begin
          n_d = 2'd1;
        end
      endcase
    end
  end

  // Result buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (exec) begin
      rem_q <= n_d;
      idx_q <= 2'd0;
    end else if (res_o.valid && res_o.ready) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      for (int i = 0; i < 3; i++) begin
        ent_q[i] <= ent_d[i];
      end
      free_q  <= FILL_MAX - fill_d;
      lines_q <= pend_d;
      wake_q  <= wake_d;
      lend_q  <= lend_d;
    end
  end

  // Result channel.
  assign res_o.valid       = (rem_q != 2'd0);
  assign res_o.kind        = 3'(ent_q[idx_q].kind);
  assign res_o.out_byte    = ent_q[idx_q].out_byte;
  assign res_o.last        = (rem_q == 2'd1);
  assign res_o.wake        = (rem_q == 2'd1) && wake_q;
  assign res_o.line_end    = (rem_q == 2'd1) && lend_q;
  assign res_o.free_space  = free_q;
  assign res_o.lines_ready = lines_q;

  // Assertions.
  `CLE_ASSERT(a_fill_bound, (fill_q <= FILL_MAX), "fill count exceeds store depth")
  `CLE_ASSERT(a_comp_bound, (comp_q <= fill_q), "completed bytes exceed fill count")
  `CLE_ASSERT(a_exec_loads, (exec |=> (rem_q != 2'd0)), "handled request left no result")
  `CLE_ASSERT(a_rem_bound, (rem_q != '0) |-> ({1'b0, idx_q} + rem_q <= 3'd3), "bad index")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for canonical_line_editor_core: random and directed requests with
// a line-discipline predictor that checks every result transfer in order.
// Depends on cle_pkg and the channel interfaces in cle_if.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH        = 4096;
  localparam int         CLK_PERIOD   = 8;
  localparam int         RESET_CYCLES = 8;
  localparam int         IDLE_PCT     = 36;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         SETTLE       = 20;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         MAX_REPORTS  = 30;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       err;
    logic       batch_end;
  } req_item_t;

  typedef struct packed {
    cle_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
    logic           wake;
    logic           line_end;
    logic [12:0]    free;
    logic [15:0]    lines;
  } res_item_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       cfg_we   = 1'b0;
  logic [2:0] cfg_idx  = '0;
  logic [7:0] cfg_data = '0;

  cle_req_if req_if ();
  cle_res_if res_if ();

  canonical_line_editor_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_wdata_i (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: ring contents, pointers, counts and the register settings.
  logic [7:0]  ring_mem [DEPTH];
  int unsigned wr_pos, rd_pos, stored, done_bytes;
  logic [15:0] lines_pend;
  bit          wake_flag;
  bit          map_cr_on, canon_on, echo_on, expand_on;
  logic [7:0]  erase_chr, eof_chr;

  req_item_t   req_backlog [$];
  res_item_t   pending_results [$];
  req_item_t   taken;
  res_item_t   want_res;
  bit          src_busy;
  bit          calm;
  int          hold_left;
  int          quiet_cycles;
  int          fail_cnt;
  int          pushed;

  function automatic res_item_t make_res(cle_pkg::kind_e k, logic [7:0] b);
    res_item_t r;
    r      = '0;
    r.kind = k;
    r.data = b;
    return r;
  endfunction

  function automatic void count_line();
    if (lines_pend != cle_pkg::LINES_MAX) lines_pend++;
  endfunction

  // Works out the results of one accepted request and queues them.
  function automatic void discipline_step(req_item_t it);
    res_item_t  outs [3];
    int         n;
    logic [7:0] ch;
    bit         woke, wake_out, read_nl;
    n        = 0;
    woke     = 1'b0;
    wake_out = 1'b0;
    read_nl  = 1'b0;
    case (it.func)
      cle_pkg::FUNC_RX: begin
        if (!it.err) begin
          ch = it.data;
          if (map_cr_on && ch == cle_pkg::CH_CR) ch = cle_pkg::CH_NL;
          if (canon_on && (ch == cle_pkg::CH_BS || ch == erase_chr)) begin
            // Erase only reaches bytes that are not yet part of a finished line.
            if (stored > done_bytes) begin
              wr_pos = (wr_pos == 0) ? DEPTH - 1 : wr_pos - 1;
              stored--;
              if (echo_on) begin
                outs[0] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
                outs[1] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_SP);
                outs[2] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_BS);
                n = 3;
              end
            end
          end else if (canon_on && ch == eof_chr) begin
            count_line();
            woke = 1'b1;
          end else if (stored < DEPTH) begin
            ring_mem[wr_pos] = ch;
            wr_pos = (wr_pos + 1 >= DEPTH) ? 0 : wr_pos + 1;
            stored++;
            if (canon_on) begin
              if (ch == cle_pkg::CH_NL || stored >= DEPTH) begin
                done_bytes = stored;
                count_line();
                woke = 1'b1;
              end
            end else begin
              woke = 1'b1;
            end
            if (echo_on) begin
              if (ch == cle_pkg::CH_NL && expand_on) begin
                outs[0] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_CR);
                outs[1] = make_res(cle_pkg::KIND_ECHO, cle_pkg::CH_NL);
                n = 2;
              end else begin
                outs[0] = make_res(cle_pkg::KIND_ECHO, ch);
                n = 1;
              end
            end
          end
        end
        if (woke) wake_flag = 1'b1;
        if (n == 0) begin
          outs[0] = make_res(cle_pkg::KIND_STATUS, 8'h00);
          n = 1;
        end
        if (it.batch_end) begin
          wake_out  = wake_flag;
          wake_flag = 1'b0;
        end
      end
      cle_pkg::FUNC_READ: begin
        if (stored == 0) begin
          if (canon_on && lines_pend != 0) begin
            lines_pend--;
            outs[0] = make_res(cle_pkg::KIND_EOF, 8'h00);
          end else begin
            outs[0] = make_res(cle_pkg::KIND_NODATA, 8'h00);
          end
        end else if (canon_on && lines_pend == 0) begin
          outs[0] = make_res(cle_pkg::KIND_NODATA, 8'h00);
        end else begin
          ch = ring_mem[rd_pos];
          rd_pos = (rd_pos + 1 >= DEPTH) ? 0 : rd_pos + 1;
          stored--;
          if (done_bytes > 0) done_bytes--;
          outs[0] = make_res(cle_pkg::KIND_READ, ch);
          if (canon_on && ch == cle_pkg::CH_NL) begin
            read_nl = 1'b1;
            if (lines_pend != 0) lines_pend--;
          end
        end
        n = 1;
      end
      cle_pkg::FUNC_FLUSH: begin
        wr_pos     = 0;
        rd_pos     = 0;
        stored     = 0;
        done_bytes = 0;
        lines_pend = '0;
        outs[0]    = make_res(cle_pkg::KIND_STATUS, 8'h00);
        n          = 1;
      end
      default: begin
        outs[0] = make_res(cle_pkg::KIND_STATUS, 8'h00);
        n       = 1;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      outs[i].free  = 13'(DEPTH - stored);
      outs[i].lines = lines_pend;
    end
    outs[n-1].last     = 1'b1;
    outs[n-1].wake     = wake_out;
    outs[n-1].line_end = read_nl;
    for (int i = 0; i < n; i++) pending_results.push_back(outs[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Sender: offers the oldest pending request and holds it until the transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      src_busy = 1'b0;
    end else if (!src_busy) begin
      if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req_if.func      <= req_backlog[0].func;
        req_if.data_byte <= req_backlog[0].data;
        req_if.rx_error  <= req_backlog[0].err;
        req_if.batch_end <= req_backlog[0].batch_end;
        req_if.valid     <= 1'b1;
        src_busy = 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // A request transfer feeds the predictor with exactly what the block took.
  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      taken.func      = req_if.func;
      taken.data      = req_if.data_byte;
      taken.err       = req_if.rx_error;
      taken.batch_end = req_if.batch_end;
      discipline_step(taken);
      void'(req_backlog.pop_front());
      src_busy = 1'b0;
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else begin
      res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual kind %0h byte %0h",
                   $time, res_if.kind, res_if.out_byte);
      end else begin
        want_res = pending_results.pop_front();
        check_field("kind", want_res.kind, res_if.kind);
        check_field("out_byte", want_res.data, res_if.out_byte);
        check_field("last", want_res.last, res_if.last);
        check_field("wake", want_res.wake, res_if.wake);
        check_field("line_end", want_res.line_end, res_if.line_end);
        check_field("free_space", want_res.free, res_if.free_space);
        check_field("lines_ready", want_res.lines, res_if.lines_ready);
      end
    end
  end

  // Watchdog: counts cycles in which nothing moves on either side.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[canonical_line_editor_core] ERROR");
    $finish;
  end

  function automatic void push_item(logic [1:0] func, logic [7:0] data, logic err, logic be);
    req_item_t it;
    it.func      = func;
    it.data      = data;
    it.err       = err;
    it.batch_end = be;
    req_backlog.push_back(it);
    pushed++;
  endfunction

  // Received bytes biased towards printable text and the current control codes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(32, 126));
    if (r < 72) return $urandom_range(0, 1) ? cle_pkg::CH_BS : erase_chr;
    if (r < 77) return eof_chr;
    return 8'($urandom);
  endfunction

  // Waits until every request has been taken and every result has arrived.
  task automatic drain();
    while (req_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      cle_pkg::REG_MAP_CR:    map_cr_on = val[0];
      cle_pkg::REG_CANONICAL: canon_on  = val[0];
      cle_pkg::REG_ECHO:      echo_on   = val[0];
      cle_pkg::REG_EXPAND_NL: expand_on = val[0];
      cle_pkg::REG_ERASE:     erase_chr = val;
      cle_pkg::REG_EOF:       eof_chr   = val;
      default:                ;
    endcase
  endtask

  task automatic set_cfg(bit map_cr, bit canon, bit echo, bit expand,
                         logic [7:0] erase, logic [7:0] eofc);
    write_reg(cle_pkg::REG_MAP_CR, 8'(map_cr));
    write_reg(cle_pkg::REG_CANONICAL, 8'(canon));
    write_reg(cle_pkg::REG_ECHO, 8'(echo));
    write_reg(cle_pkg::REG_EXPAND_NL, 8'(expand));
    write_reg(cle_pkg::REG_ERASE, erase);
    write_reg(cle_pkg::REG_EOF, eofc);
  endtask

  // Mostly whole lines followed by reads, with some noise, flushes and spare requests.
  task automatic random_phase(int n);
    int goal, r, len;
    goal = pushed + n;
    while (pushed < goal) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          push_item(cle_pkg::FUNC_RX, pick_byte(), $urandom_range(0, 19) == 0, 1'b0);
        push_item(cle_pkg::FUNC_RX, $urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_NL,
                  1'b0, $urandom_range(0, 3) != 0);
        for (int k = 0; k <= len; k++)
          push_item(cle_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (r <= 8) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 9);
          push_item(r <= 5 ? cle_pkg::FUNC_RX : (r <= 8 ? cle_pkg::FUNC_READ : FUNC_SPARE),
                    $urandom_range(0, 1) ? pick_byte() : 8'($urandom),
                    $urandom_range(0, 3) == 0, 1'($urandom));
        end
      end else begin
        push_item($urandom_range(0, 1) ? cle_pkg::FUNC_FLUSH : FUNC_SPARE, 8'($urandom),
                  1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.func      = cle_pkg::FUNC_RX;
    req_if.data_byte = '0;
    req_if.rx_error  = 1'b0;
    req_if.batch_end = 1'b0;
    res_if.ready     = 1'b0;
    map_cr_on  = 1'b1;
    canon_on   = 1'b1;
    echo_on    = 1'b1;
    expand_on  = 1'b1;
    erase_chr  = cle_pkg::ERASE_RESET;
    eof_chr    = cle_pkg::EOF_RESET;
    wr_pos     = 0;
    rd_pos     = 0;
    stored     = 0;
    done_bytes = 0;
    lines_pend = '0;
    wake_flag  = 1'b0;
    calm       = 1'b0;
    hold_left  = 0;
    fail_cnt   = 0;
    pushed     = 0;
    rst_n      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset settings.
    push_item(cle_pkg::FUNC_RX, 8'h00, 1'b0, 1'b0);         // zero byte is stored and echoed
    push_item(cle_pkg::FUNC_RX, 8'hFF, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_RX, "x", 1'b1, 1'b1);           // byte with a receive error
    push_item(cle_pkg::FUNC_RX, cle_pkg::CH_BS, 1'b0, 1'b0);       // backspace erases
    push_item(cle_pkg::FUNC_RX, cle_pkg::ERASE_RESET, 1'b0, 1'b0); // erase code erases
    push_item(cle_pkg::FUNC_RX, cle_pkg::ERASE_RESET, 1'b0, 1'b0); // nothing left to erase
    push_item(cle_pkg::FUNC_RX, "h", 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_RX, cle_pkg::CH_CR, 1'b0, 1'b1);  // CR mapped, echoed as CR LF
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_RX, cle_pkg::EOF_RESET, 1'b0, 1'b1);   // end-of-file mark
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(FUNC_SPARE, 8'hFF, 1'b1, 1'b1);               // unused request code
    push_item(cle_pkg::FUNC_RX, "q", 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);       // unfinished line is not readable
    push_item(cle_pkg::FUNC_FLUSH, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_RX, cle_pkg::CH_NL, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_RX, "k", 1'b0, 1'b1);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    push_item(cle_pkg::FUNC_READ, 8'h00, 1'b0, 1'b0);
    drain();

    // Long receiver hold-off while requests keep coming, so the block backs up.
    hold_left = HOLD_CYCLES;
    random_phase(80);
    drain();

    set_cfg(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 8'hFF);
    random_phase(80);
    drain();

    set_cfg(1'b1, 1'b0, 1'b0, 1'b1, 8'hFF, 8'h00);
    random_phase(80);
    drain();

    set_cfg(1'b0, 1'b0, 1'b1, 1'b1, cle_pkg::CH_BS, cle_pkg::CH_CR);
    random_phase(70);
    drain();

    set_cfg(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
            8'($urandom));
    random_phase(30);
    drain();

    // Reset settings again, with no idling on either side.
    set_cfg(1'b1, 1'b1, 1'b1, 1'b1, cle_pkg::ERASE_RESET, cle_pkg::EOF_RESET);
    calm = 1'b1;
    random_phase(20);
    drain();
    calm = 1'b0;

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("[canonical_line_editor_core] OK");
    end else begin
      $display("[canonical_line_editor_core] ERROR");
    end
    $finish;
  end

endmodule
